[hw/rtl/assert_macros.svh]
// Assertion macros used by the engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define FBH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define FBH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/fbh_pkg.sv]
// Package: types, constants and the FNV prime multiply for the byte hash engine.
`default_nettype none

package fbh_pkg;

  localparam int unsigned HASH_W   = 64;
  localparam int unsigned NARROW_W = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDE_MODE  = 8'd0,
    CFG_XOR_FIRST  = 8'd1,
    CFG_FOLD_CASE  = 8'd2,
    CFG_START_SEED = 8'd3
  } cfg_idx_t;

  localparam logic [HASH_W-1:0] SEED_RESET = 64'd2166136261;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam int unsigned       CASE_BIT = 5;

  typedef struct packed {
    logic wide_mode;
    logic xor_first;
    logic fold_case;
  } fbh_mode_t;

  // Multiply by the FNV prime as shift-add terms.
  // 16777619 = 2^24 + 0x193, 0x100000001B3 = 2^40 + 0x1B3.
  function automatic logic [HASH_W-1:0] prime_mul(input logic [HASH_W-1:0] v,
                                                  input logic wide);
    logic [NARROW_W-1:0] n;
    logic [NARROW_W-1:0] pn;
    logic [HASH_W-1:0]   pw;
    n  = v[NARROW_W-1:0];
    pn = (n << 24) + (n << 8) + (n << 7) + (n << 4) + (n << 1) + n;
    pw = (v << 40) + (v << 8) + (v << 7) + (v << 5) + (v << 4) + (v << 1) + v;
    return wide ? pw : {{(HASH_W-NARROW_W){1'b0}}, pn};
  endfunction

endpackage

`default_nettype wire

[hw/rtl/fbh_if.sv]
// Channel interfaces: byte input, digest output and configuration write.
`default_nettype none

interface fbh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty_message;
  modport source (output valid, output data_byte, output last_byte, output empty_message,
                  input ready);
  modport sink (input valid, input data_byte, input last_byte, input empty_message,
                output ready);
endinterface

interface fbh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest;
  modport source (output valid, output digest, input ready);
  modport sink (input valid, input digest, output ready);
endinterface

interface fbh_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/fbh_mix.sv]
// One FNV mixing step: case fold, xor and prime multiply at the selected width.
`default_nettype none

module fbh_mix (
  input  var fbh_pkg::fbh_mode_t              mode,
  input  var logic [fbh_pkg::HASH_W-1:0]      hash_in,
  input  var logic [fbh_pkg::BYTE_W-1:0]      data_byte,
  output var logic [fbh_pkg::HASH_W-1:0]      hash_out
);
  import fbh_pkg::*;

  logic [BYTE_W-1:0] byte_f;
  logic [HASH_W-1:0] mask;
  logic [HASH_W-1:0] h;
  logic [HASH_W-1:0] b_ext;
  logic [HASH_W-1:0] res;

  always_comb begin
    byte_f = data_byte;
    if (mode.fold_case && data_byte >= ASCII_UPPER_A && data_byte <= ASCII_UPPER_Z) begin
      byte_f[CASE_BIT] = 1'b1;
    end
    mask  = mode.wide_mode ? {HASH_W{1'b1}} : {{(HASH_W-NARROW_W){1'b0}}, {NARROW_W{1'b1}}};
    h     = hash_in & mask;
    b_ext = {{(HASH_W-BYTE_W){1'b0}}, byte_f};
    if (mode.xor_first) begin
      res = prime_mul(h ^ b_ext, mode.wide_mode);
    end else begin
      res = prime_mul(h, mode.wide_mode) ^ b_ext;
    end
    hash_out = res & mask;
  end

endmodule

`default_nettype wire

[hw/rtl/fnv_byte_hash_engine.sv]
// Top level of the streaming FNV byte hash engine.
// Takes one message byte per cycle while no last item is held, at a rate set
// by the loop from the hash register through the shift-add prime multiply, and
// keeps a running FNV-1a or FNV-1 hash at 32 or 64 bits. After its last byte
// is transferred in, the digest of a message passes from the input register
// through the digest register to the output channel. These two registers
// separate the channels, so bytes keep flowing while a digest waits; only the
// next last item holds in the input register until that digest is taken.
// The seed loads at the first byte of each message; a last item flagged empty
// closes the message without mixing its byte. Configuration writes are taken
// every cycle and belong only where no item is in flight; a width change inside
// a message applies from the next byte, a seed change at the next message start.
`default_nettype none

module fnv_byte_hash_engine (
  input  var logic   clk,
  input  var logic   rst_n,
  fbh_in_if.sink     in_ch,
  fbh_out_if.source  out_ch,
  fbh_cfg_if.sink    cfg_ch
);
  import fbh_pkg::*;

  `include "assert_macros.svh"

  // configuration
  fbh_mode_t         mode_r;
  logic [HASH_W-1:0] seed_r;

  // input stage
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              s1_empty_r;

  // hash state
  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] hash_nxt;
  logic              open_r;

  // result stage
  logic              out_valid_r;
  logic [HASH_W-1:0] digest_r;

  logic              s1_adv;
  logic              in_ready;
  logic              in_xfer;
  logic [HASH_W-1:0] base;
  logic [HASH_W-1:0] mixed;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '{wide_mode: 1'b0, xor_first: 1'b1, fold_case: 1'b0};
      seed_r <= SEED_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_WIDE_MODE:  mode_r.wide_mode <= cfg_ch.data[0];
        CFG_XOR_FIRST:  mode_r.xor_first <= cfg_ch.data[0];
        CFG_FOLD_CASE:  mode_r.fold_case <= cfg_ch.data[0];
        CFG_START_SEED: seed_r           <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r  <= in_ch.data_byte;
      s1_last_r  <= in_ch.last_byte;
      s1_empty_r <= in_ch.empty_message;
    end
  end

  // seed at message start, masked to the current width
  always_comb begin
    if (open_r) begin
      base = hash_r;
    end else if (mode_r.wide_mode) begin
      base = seed_r;
    end else begin
      base = {{(HASH_W-NARROW_W){1'b0}}, seed_r[NARROW_W-1:0]};
    end
  end

  fbh_mix u_mix (
    .mode      (mode_r),
    .hash_in   (base),
    .data_byte (s1_byte_r),
    .hash_out  (mixed)
  );

  always_comb begin
    if (s1_last_r && s1_empty_r) begin
      hash_nxt = mode_r.wide_mode ? base
                                  : {{(HASH_W-NARROW_W){1'b0}}, base[NARROW_W-1:0]};
    end else begin
      hash_nxt = mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
      open_r <= 1'b0;
    end else if (s1_adv) begin
      hash_r <= hash_nxt;
      open_r <= !s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      digest_r <= hash_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.digest = digest_r;

  `FBH_ASSERT_ALWAYS(a_stall_has_item, !in_ready |-> s1_valid_r, "input stalled with empty stage")
  `FBH_ASSERT(a_no_overwrite, (s1_adv && s1_last_r) |-> (!out_valid_r || out_ch.ready),
              "digest register overwritten")
  `FBH_ASSERT(a_last_closes, (s1_adv && s1_last_r) |=> !open_r, "message not closed on last")
  `FBH_ASSERT(a_byte_opens, (s1_adv && !s1_last_r) |=> open_r, "message not opened on byte")

endmodule

`default_nettype wire
